// ----- rtl/core/dmc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants for the direct-mapped cache tag model: register
// codes, fixed field widths and the command/status bundle between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Fixed field widths
  localparam int TAG_W      = 32;
  localparam int LINE_OUT_W = 10;
  localparam int CNT_W      = 48;
  localparam int OFF_W      = 3;
  localparam int IBITS_W    = 4;
  localparam int SHAMT_W    = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Register reset values
  localparam logic [OFF_W-1:0]   OFF_RESET   = 3'd3;
  localparam logic [IBITS_W-1:0] IBITS_RESET = 4'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_OFFSET_BITS = 1'b0,
    REG_INDEX_BITS        = 1'b1
  } cfg_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;      // write one valid entry of the clearing pass
    logic load_addr;  // capture the incoming address beat
    logic lookup;     // split address, read tag and valid stores
    logic commit;     // compare, update stores and counters, load result
  } dmc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last; // clearing pass is at its last entry
    logic out_busy;   // result register full and stalled
  } dmc_sts_t;

endpackage : dmc_pkg
`default_nettype wire

// ----- rtl/core/dmc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer for the tag model: runs the valid-store clearing pass after
// reset, then walks each accepted access through lookup and commit.
// ----------------------------------------------------------------------------
module dmc_ctrl
  import dmc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dmc_sts_t sts_i,
  output dmc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clear_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_CMP;
      S_CMP:   if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Drive commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.clear     = (state_q == S_CLEAR);
    cmd_o.load_addr = (state_q == S_IDLE) && in_valid_i;
    cmd_o.lookup    = (state_q == S_READ);
    cmd_o.commit    = (state_q == S_CMP) && !sts_i.out_busy;
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Checks
  a_load_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_addr |=> cmd_o.lookup)
    else $error("accepted beat not followed by lookup");

  a_read_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.lookup |=> (state_q == S_CMP))
    else $error("lookup not followed by compare");

  a_wait_keeps_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) && sts_i.out_busy |=> (state_q == S_CMP))
    else $error("compare left while result register blocked");

endmodule : dmc_ctrl
`default_nettype wire

// ----- rtl/core/dmc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_datapath
// Address split, tag and valid stores, hit/access counters, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module dmc_datapath
  import dmc_pkg::*;
#(
  parameter int MAX_LINES  = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dmc_cmd_t              cmd_i,
  output dmc_sts_t              sts_o,
  input  logic [ADDR_WIDTH-1:0] address_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [LINE_OUT_W-1:0] line_index_o,
  output logic [CNT_W-1:0]      hit_total_o,
  output logic [CNT_W-1:0]      access_total_o
);

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int MAXB  = $clog2(MAX_LINES + 1) - 1;
  localparam int EXT_W = ADDR_WIDTH + TAG_W + IDX_W;

  // Configuration registers
  logic [OFF_W-1:0]   boff_q;
  logic [IBITS_W-1:0] ibits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boff_q  <= OFF_RESET;
      ibits_q <= IBITS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BLOCK_OFFSET_BITS: boff_q  <= cfg_data_i[OFF_W-1:0];
        REG_INDEX_BITS:        ibits_q <= cfg_data_i[IBITS_W-1:0];
        default:               ;
      endcase
    end
  end

  // Capture the address beat
  logic [ADDR_WIDTH-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_addr) begin
      addr_q <= address_i;
    end
  end

  // Split the address into line index and tag
  logic [SHAMT_W-1:0] ib_sat;
  logic [EXT_W-1:0]   shifted;
  logic [EXT_W-1:0]   tag_full;
  logic [IDX_W-1:0]   line;
  logic [TAG_W-1:0]   tag;

  always_comb begin
    ib_sat   = (SHAMT_W'(ibits_q) > SHAMT_W'(MAXB)) ? SHAMT_W'(MAXB) : SHAMT_W'(ibits_q);
    shifted  = EXT_W'(addr_q) >> boff_q;
    tag_full = shifted >> ib_sat;
    line     = shifted[IDX_W-1:0] & ~({IDX_W{1'b1}} << ib_sat);
    tag      = tag_full[TAG_W-1:0];
  end

  // Tag and valid stores
  logic [TAG_W-1:0] tag_mem [MAX_LINES];
  logic             valid_mem [MAX_LINES];
  logic [IDX_W-1:0] clr_q;
  logic [IDX_W-1:0] line_q;
  logic [TAG_W-1:0] tag_q;
  logic [TAG_W-1:0] rd_tag_q;
  logic             rd_valid_q;
  logic             hit;

  assign hit = rd_valid_q && (rd_tag_q == tag_q);

  // Read both stores at the computed line
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      line_q     <= line;
      tag_q      <= tag;
      rd_tag_q   <= tag_mem[line];
      rd_valid_q <= valid_mem[line];
    end
  end

  // Replace the tag on a miss
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit) begin
      tag_mem[line_q] <= tag_q;
    end
  end

  // Clear valid entries after reset, set them on a miss
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      valid_mem[clr_q] <= 1'b0;
    end else if (cmd_i.commit && !hit) begin
      valid_mem[line_q] <= 1'b1;
    end
  end

  // Advance the clearing pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + IDX_W'(1);
    end
  end

  // Running counters
  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] acc_cnt_q, acc_cnt_d;

  assign hit_cnt_d = hit_cnt_q + CNT_W'(hit);
  assign acc_cnt_d = acc_cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q <= '0;
      acc_cnt_q <= '0;
    end else if (cmd_i.commit) begin
      hit_cnt_q <= hit_cnt_d;
      acc_cnt_q <= acc_cnt_d;
    end
  end

  // Result register
  logic                  out_valid_q;
  logic                  hit_q;
  logic [LINE_OUT_W-1:0] line_out_q;
  logic [CNT_W-1:0]      hit_tot_q;
  logic [CNT_W-1:0]      acc_tot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q      <= hit;
      line_out_q <= LINE_OUT_W'(line_q);
      hit_tot_q  <= hit_cnt_d;
      acc_tot_q  <= acc_cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign line_index_o   = line_out_q;
  assign hit_total_o    = hit_tot_q;
  assign access_total_o = acc_tot_q;

  assign sts_o.clear_last = (clr_q == IDX_W'(MAX_LINES - 1));
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  // Checks
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && out_stall_i))
    else $error("commit into a blocked result register");

  a_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clear && (cmd_i.commit || cmd_i.lookup)))
    else $error("access overlaps the clearing pass");

  a_acc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (acc_cnt_q == $past(acc_cnt_q) + CNT_W'(1)))
    else $error("access counter did not step by one");

  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(acc_cnt_q))
    else $error("access counter moved without a commit");

endmodule : dmc_datapath
`default_nettype wire

// ----- rtl/core/direct_mapped_cache_tag_model.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_model
// Direct-mapped cache hit/miss tracker with running hit and access totals.
// ----------------------------------------------------------------------------
// Each address beat is accepted first; then the address is split and the tag
// and valid stores are read (single-port memories with registered read data);
// then the block compares, replaces the tag on a miss, bumps the counters and
// loads the result register. The commit cycle waits while the result register
// holds an untaken, stalled result; a new address is still accepted while an
// older result waits. After reset the valid store is cleared one line per
// cycle, and the input stalls until the clearing pass is done; configuration
// writes are taken at any time (cfg_ready_o is always high) and must only be
// issued while the block is idle.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_model
  import dmc_pkg::*;
#(
  parameter int MAX_LINES  = 1024,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADDR_WIDTH-1:0] address_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [LINE_OUT_W-1:0] line_index_o,
  output logic [CNT_W-1:0]      hit_total_o,
  output logic [CNT_W-1:0]      access_total_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dmc_cmd_t cmd;
  dmc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dmc_datapath #(
    .MAX_LINES  (MAX_LINES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .address_i      (address_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .line_index_o   (line_index_o),
    .hit_total_o    (hit_total_o),
    .access_total_o (access_total_o)
  );

endmodule : direct_mapped_cache_tag_model
`default_nettype wire

// ----- dv/tb_direct_mapped_cache_tag_model.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_cache_tag_model
// Self-checking bench for the direct-mapped cache tag model. A queue-fed
// driver offers address beats in bursts with random gaps. Every accepted beat
// runs through a local tag/valid mirror, which gives the expected hit flag,
// line, and running totals. A monitor under a random stall pattern checks
// each result beat field by field. Phases switch the offset and index widths
// between runs, and include the register extremes, a long receiver hold-off
// and a workload with strong locality so that hits are frequent.
// ----------------------------------------------------------------------------
module tb_direct_mapped_cache_tag_model
  import dmc_pkg::*;
;

  localparam int MAX_LINES     = 1024;
  localparam int LINE_BITS     = $clog2(MAX_LINES);
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 173;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 30;

  typedef struct packed {
    logic                  hit;
    logic [LINE_OUT_W-1:0] line;
    logic [CNT_W-1:0]      hits;
    logic [CNT_W-1:0]      accesses;
  } lookup_result_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [31:0]           address_i      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic                  hit_o;
  logic [LINE_OUT_W-1:0] line_index_o;
  logic [CNT_W-1:0]      hit_total_o;
  logic [CNT_W-1:0]      access_total_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // Mirror of the cache state and registers
  logic [OFF_W-1:0]   offset_cfg = OFF_RESET;
  logic [IBITS_W-1:0] ibits_cfg  = IBITS_RESET;
  logic [TAG_W-1:0]   line_tag [MAX_LINES];
  bit                 line_ok  [MAX_LINES];
  logic [CNT_W-1:0]   hit_count    = '0;
  logic [CNT_W-1:0]   access_count = '0;

  // Stimulus and checking bookkeeping
  logic [31:0]    addr_queue [$];
  lookup_result_t expected_lookups [$];
  lookup_result_t oldest;
  logic [31:0]    recent_addr [16];
  logic [31:0]    region_base;
  int             gap_max       = 0;
  int             stall_pct     = 0;
  int             hold_len      = 0;
  int             hold_req_seq  = 0;
  int             burst_left    = 0;
  int             gap_left      = 0;
  int             stall_run     = 0;
  int             hold_left     = 0;
  int             hold_seen_seq = 0;
  int             mismatch_count  = 0;
  int             results_checked = 0;
  int             hits_seen       = 0;
  int             config_writes   = 0;

  direct_mapped_cache_tag_model u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .line_index_o   (line_index_o),
    .hit_total_o    (hit_total_o),
    .access_total_o (access_total_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Index width in use: register values past the store depth saturate
  function automatic int unsigned used_index_bits();
    return (ibits_cfg > LINE_BITS) ? LINE_BITS : ibits_cfg;
  endfunction

  // Look up one address in the mirror, update it, and return the result
  function automatic lookup_result_t lookup_line(logic [31:0] addr);
    lookup_result_t r;
    int unsigned    ib;
    logic [31:0]    line_no;
    logic [31:0]    tag;
    ib      = used_index_bits();
    line_no = (addr >> offset_cfg) & ((32'd1 << ib) - 32'd1);
    tag     = addr >> (offset_cfg + ib);
    r.hit   = line_ok[line_no] && (line_tag[line_no] == tag);
    if (r.hit) begin
      hit_count++;
    end else begin
      line_tag[line_no] = tag;
      line_ok[line_no]  = 1'b1;
    end
    access_count++;
    r.line     = line_no[LINE_OUT_W-1:0];
    r.hits     = hit_count;
    r.accesses = access_count;
    return r;
  endfunction

  // Draw an address: mostly reuse and conflicts on recent lines, some noise
  function automatic logic [31:0] next_address();
    logic [31:0] a;
    int unsigned pick;
    int unsigned sh;
    pick = $urandom_range(99);
    sh   = offset_cfg + used_index_bits();
    if (pick < 55) begin
      // same block, another byte
      a = recent_addr[$urandom_range(15)] ^ 32'($urandom_range((1 << offset_cfg) - 1));
    end else if (pick < 75) begin
      // same line, another tag
      a = recent_addr[$urandom_range(15)] ^ (32'd1 << $urandom_range(31, sh));
    end else if (pick < 90) begin
      a = region_base + 32'($urandom_range(4095));
    end else begin
      a = $urandom;
    end
    recent_addr[$urandom_range(15)] = a;
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s at result %0d: got 'h%0h, want 'h%0h",
               what, results_checked, got, want);
  endtask

  // Write one register; call right after a rising edge, caller drops valid
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_BLOCK_OFFSET_BITS) offset_cfg = data[OFF_W-1:0];
    else ibits_cfg = data[IBITS_W-1:0];
    config_writes++;
  endtask

  // Wait until every queued beat is sent and every result is back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (addr_queue.size() != 0 || in_valid_i || expected_lookups.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] off_data, logic [CFG_DATA_W-1:0] ib_data);
    write_reg(REG_BLOCK_OFFSET_BITS, off_data);
    write_reg(REG_INDEX_BITS, ib_data);
    cfg_valid_i <= 1'b0;
  endtask

  // Driver: send address beats in bursts, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      address_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_lookups.push_back(lookup_line(address_i));
      if (in_valid_i && in_stall_o) begin
        // hold the beat
      end else if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (addr_queue.size() != 0) begin
        in_valid_i <= 1'b1;
        address_i  <= addr_queue.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12, 1);
          gap_left   <= (gap_max == 0) ? 0 : $urandom_range(gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: long hold on request, else random runs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      stall_run     <= 0;
      hold_left     <= 0;
      hold_seen_seq <= 0;
    end else if (hold_seen_seq != hold_req_seq) begin
      hold_seen_seq <= hold_req_seq;
      hold_left     <= hold_len;
      out_stall_i   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      stall_run   <= $urandom_range(5);
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("result with nothing pending", access_total_o, 0);
      end else begin
        oldest = expected_lookups.pop_front();
        if (hit_o !== oldest.hit) report_mismatch("hit", hit_o, oldest.hit);
        if (line_index_o !== oldest.line) report_mismatch("line_index", line_index_o, oldest.line);
        if (hit_total_o !== oldest.hits) report_mismatch("hit_total", hit_total_o, oldest.hits);
        if (access_total_o !== oldest.accesses)
          report_mismatch("access_total", access_total_o, oldest.accesses);
        results_checked++;
        if (hit_o === 1'b1) hits_seen++;
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_lookups.size());
    $display("status: fail");
    $finish;
  end

  // Sequence: reset, directed checks, then random phases
  initial begin
    logic [CFG_DATA_W-1:0] off_data;
    logic [CFG_DATA_W-1:0] ib_data;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset widths: repeat hits, block boundary, conflict on line zero
    addr_queue = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0007, 32'h0000_0008,
                   32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'h0000_1000, 32'h0000_0000,
                   32'hAAAA_AAAA, 32'h5555_5555};
    wait_idle();

    // Zero offset and zero index: a single line, all bits are tag
    set_config(4'd0, 4'd0);
    addr_queue = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h0000_0001};
    wait_idle();

    // Offset of seven, index width past the depth
    set_config(4'd7, 4'd15);
    gap_max   = 2;
    stall_pct = 30;
    addr_queue = '{32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'hFFFF_FFFF,
                   32'hFFFE_0000};
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin off_data = 4'd0; ib_data = 4'd10; end
        1: begin off_data = 4'd7; ib_data = 4'd0;  end
        2: begin off_data = 4'd3; ib_data = 4'd9;  end
        3: begin off_data = 4'hE; ib_data = 4'd11; end
        default: begin
          off_data = 4'($urandom_range(15));
          ib_data  = 4'($urandom_range(15));
        end
      endcase
      set_config(off_data, ib_data);
      gap_max   = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 4 : 10);
      stall_pct = (p % 4) * 25;
      region_base = $urandom;
      foreach (recent_addr[k]) recent_addr[k] = region_base + 32'($urandom_range(4095));
      // Back up the block: receiver holds off while the sender keeps offering
      if (p == 2 || p == 7) begin
        gap_max  = 0;
        hold_len = 150 + $urandom_range(150);
        hold_req_seq++;
      end
      repeat (PHASE_ITEMS) addr_queue.push_back(next_address());
      wait_idle();
    end

    $display("summary: %0d accesses checked, %0d hits, %0d register writes",
             results_checked, hits_seen, config_writes);
    $display("summary: offset and index widths at their extremes, random traffic with stalls");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dmc_pkg.sv
rtl/core/dmc_ctrl.sv
rtl/core/dmc_datapath.sv
rtl/core/direct_mapped_cache_tag_model.sv
dv/tb_direct_mapped_cache_tag_model.sv
